// ===== hdl/its_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package its_pkg;
  localparam int Channels = 8;
  localparam int ChW = 3;
  localparam int TsW = 48;
  localparam logic signed [31:0] MinStart = 32'sd99999999;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_MARK  = 2'd1,
    ACT_CLOSE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_DIFF, ST_SAT, ST_MUL, ST_UPD,
    ST_CNT, ST_RRD, ST_RWAIT, ST_DIV0, ST_DIV1, ST_DIVW, ST_MSQ, ST_MSQ2, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] mag;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  // Channel statistics word held in the statistics memory
  typedef struct packed {
    logic signed [31:0] mn;
    logic signed [31:0] mx;
    logic [63:0]        sum;
    logic [63:0]        sq;
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/interval_timing_statistics_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | payload
// in_     | slave     | action, channel, timestamp
// out_    | master    | report_channel..sample_count, tlast = last
// cfg_    | slave     | active_channels
// Start and mark write the mark memory on acceptance. Close first walks the channels
// to update their statistics, then reports each channel with the bit-serial 64-bit
// divider, used twice per channel. Reset is synchronous, active low, and clears all
// stored statistics and mark times via valid bits. Output stalls hold the report walk.
module interval_timing_statistics_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_tvalid,
  output logic              cfg_tready,
  input  wire logic [7:0]   cfg_tdata,   // active_channels[3:0]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,    // action[1:0], channel[4:2], timestamp[52:5]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [199:0]      out_tdata,   // report_channel, mean, variance, min, max, count
  output logic              out_tlast
);
  logic [194:0] od;
  its_core u_core (
    .clk(clk), .rst_n(rst_n),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata[3:0]),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(od),
    .out_tlast(out_tlast)
  );
  assign out_tdata = {5'd0, od};
endmodule
`default_nettype wire

// ===== hdl/its_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module its_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire its_pkg::div_req_t req,
  output its_pkg::div_rsp_t      rsp
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;

  // One quotient bit per cycle, restoring
  always_comb begin
    trial   = {rem_r[31:0], q_r[63]};
    q_nxt   = {q_r[62:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        q_r    <= req.mag;
        rem_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.neg;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (64'd0 - q_r) : q_r;
endmodule
`default_nettype wire

// ===== hdl/its_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module its_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_tvalid,
  output logic              cfg_tready,
  input  wire logic [3:0]   cfg_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [55:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [194:0]      out_tdata,
  output logic              out_tlast
);
  localparam int MarkW = $clog2(its_pkg::Channels + 1);

  its_pkg::state_t state_r, state_nxt;
  logic [3:0] active_r;
  logic [31:0] samples_r;

  // Mark memory: entry 0 reference, 1+c channel marks
  logic [its_pkg::TsW-1:0] mark_mem [its_pkg::Channels+1];
  logic [its_pkg::TsW-1:0] mark_rd_r;
  logic [MarkW-1:0]        mark_ra;
  logic                    mark_we;
  logic [MarkW-1:0]        mark_wa;
  logic [its_pkg::Channels:0] mval_r;
  logic                    mval_rd_r;
  logic [its_pkg::TsW-1:0] mark_cur;

  // Statistics memory, lazily initialised through valid bits
  its_pkg::stat_t stat_mem [its_pkg::Channels];
  its_pkg::stat_t stat_rd_r, stat_wd;
  logic [its_pkg::Channels-1:0] sval_r;
  logic                         sval_rd_r;
  logic                         stat_we;
  its_pkg::stat_t stat_cur;

  logic [its_pkg::ChW-1:0] ch_r;
  logic [3:0]  n_r;
  logic [its_pkg::TsW-1:0] prev_r;
  logic signed [its_pkg::TsW:0] diff_r;
  logic signed [31:0] iv_r;
  logic signed [63:0] sq_r;
  logic [63:0] mbits_r, msq_r;
  logic signed [31:0] mean_r;
  logic signed [63:0] msq_mean_r;
  its_pkg::stat_t rep_r;

  its_pkg::div_req_t dreq;
  its_pkg::div_rsp_t drsp;

  logic [1:0] act;
  logic [its_pkg::ChW-1:0] in_ch;
  logic [its_pkg::TsW-1:0] in_ts;

  logic [194:0] obuf_r;
  logic         olast_r, ovalid_r;

  assign act   = in_tdata[1:0];
  assign in_ch = in_tdata[4:2];
  assign in_ts = in_tdata[52:5];
  assign cfg_tready = 1'b1;
  assign in_tready  = (state_r == its_pkg::ST_IDLE);
  assign stat_cur   = sval_rd_r ? stat_rd_r
                      : '{mn: its_pkg::MinStart, mx: 32'sd0, sum: 64'd0, sq: 64'd0};
  // Unwritten mark entries read as zero
  assign mark_cur   = mval_rd_r ? mark_rd_r : '0;

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= in_ts;
    mark_rd_r <= mark_mem[mark_ra];
    mval_rd_r <= mval_r[mark_ra];
    if (stat_we) stat_mem[ch_r] <= stat_wd;
    stat_rd_r <= stat_mem[ch_r];
    sval_rd_r <= sval_r[ch_r];
  end

  always_comb begin
    mark_we = 1'b0;
    mark_wa = '0;
    if (in_tvalid && in_tready) begin
      if (act == its_pkg::ACT_START) mark_we = 1'b1;
      if (act == its_pkg::ACT_MARK) begin
        mark_we = 1'b1;
        mark_wa = MarkW'({1'b0, in_ch} + 4'd1);
      end
    end
  end
  // Read channel's own mark; previous value is carried in prev_r
  assign mark_ra = (state_r == its_pkg::ST_IDLE) ? '0 : MarkW'({1'b0, ch_r} + 4'd1);

  always_comb begin
    stat_wd = stat_cur;
    if (iv_r < stat_cur.mn) stat_wd.mn = iv_r;
    if (iv_r > stat_cur.mx) stat_wd.mx = iv_r;
    stat_wd.sum = stat_cur.sum + 64'(iv_r);
    stat_wd.sq  = stat_cur.sq + sq_r;
  end
  assign stat_we = (state_r == its_pkg::ST_UPD);

  always_comb begin
    dreq = '0;
    if (state_r == its_pkg::ST_DIV0) begin
      dreq.start = 1'b1;
      dreq.neg   = rep_r.sum[63];
      dreq.mag   = rep_r.sum[63] ? 64'd0 - rep_r.sum : rep_r.sum;
      dreq.den   = samples_r;
    end else if (state_r == its_pkg::ST_DIV1) begin
      dreq.start = 1'b1;
      dreq.neg   = rep_r.sq[63];
      dreq.mag   = rep_r.sq[63] ? 64'd0 - rep_r.sq : rep_r.sq;
      dreq.den   = samples_r;
    end
  end

  its_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      its_pkg::ST_IDLE: begin
        if (in_tvalid && act == its_pkg::ACT_CLOSE) state_nxt = its_pkg::ST_RD;
      end
      its_pkg::ST_RD: state_nxt = (n_r == 4'd0) ? its_pkg::ST_CNT : its_pkg::ST_DIFF;
      its_pkg::ST_DIFF: state_nxt = its_pkg::ST_SAT;
      its_pkg::ST_SAT: state_nxt = its_pkg::ST_MUL;
      its_pkg::ST_MUL: state_nxt = its_pkg::ST_UPD;
      its_pkg::ST_UPD: begin
        // revisit the read state so the next channel's mark arrives
        if ({1'b0, ch_r} + 4'd1 == n_r) state_nxt = its_pkg::ST_CNT;
        else state_nxt = its_pkg::ST_RD;
      end
      its_pkg::ST_CNT: state_nxt = (n_r == 4'd0) ? its_pkg::ST_IDLE : its_pkg::ST_RRD;
      its_pkg::ST_RRD: state_nxt = its_pkg::ST_RWAIT;
      its_pkg::ST_RWAIT: state_nxt = its_pkg::ST_DIV0;
      its_pkg::ST_DIV0: state_nxt = its_pkg::ST_DIVW;
      its_pkg::ST_DIVW: if (drsp.done) state_nxt = its_pkg::ST_DIV1;
      its_pkg::ST_DIV1: state_nxt = its_pkg::ST_MSQ;
      its_pkg::ST_MSQ: if (drsp.done) state_nxt = its_pkg::ST_MSQ2;
      its_pkg::ST_MSQ2: if (!ovalid_r || out_tready) state_nxt = its_pkg::ST_OUT;
      its_pkg::ST_OUT: begin
        if ({1'b0, ch_r} + 4'd1 == n_r) state_nxt = its_pkg::ST_IDLE;
        else state_nxt = its_pkg::ST_RRD;
      end
      default: state_nxt = its_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= its_pkg::ST_IDLE;
      active_r <= 4'd8;
      samples_r <= '0;
      sval_r   <= '0;
      mval_r   <= '0;
      ovalid_r <= 1'b0;
      ch_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid) active_r <= cfg_tdata;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (stat_we) sval_r[ch_r] <= 1'b1;
      if (mark_we) mval_r[mark_wa] <= 1'b1;
      unique case (state_r)
        its_pkg::ST_IDLE: begin
          ch_r <= '0;
          n_r  <= (active_r > 4'(its_pkg::Channels)) ? 4'(its_pkg::Channels) : active_r;
        end
        its_pkg::ST_RD: prev_r <= mark_cur;
        its_pkg::ST_DIFF: diff_r <= $signed({1'b0, mark_cur}) - $signed({1'b0, prev_r});
        its_pkg::ST_SAT: begin
          prev_r <= mark_cur;
          if (diff_r > 49'sd2147483647) iv_r <= 32'sh7fffffff;
          else if (diff_r < -49'sd2147483648) iv_r <= 32'sh80000000;
          else iv_r <= diff_r[31:0];
        end
        its_pkg::ST_MUL: sq_r <= iv_r * iv_r;
        its_pkg::ST_UPD: if ({1'b0, ch_r} + 4'd1 != n_r) ch_r <= ch_r + 1'b1;
        its_pkg::ST_CNT: begin
          ch_r <= '0;
          if (samples_r != 32'hffffffff) samples_r <= samples_r + 32'd1;
        end
        its_pkg::ST_RWAIT: rep_r <= stat_cur;
        its_pkg::ST_DIV1: mbits_r <= drsp.quot;
        its_pkg::ST_MSQ: begin
          if ($signed(mbits_r) > 64'sd2147483647) mean_r <= 32'sh7fffffff;
          else if ($signed(mbits_r) < -64'sd2147483648) mean_r <= 32'sh80000000;
          else mean_r <= mbits_r[31:0];
          msq_r <= drsp.quot;
        end
        its_pkg::ST_MSQ2: if (state_nxt == its_pkg::ST_OUT) msq_mean_r <= mean_r * mean_r;
        its_pkg::ST_OUT: begin
          ovalid_r <= 1'b1;
          olast_r  <= ({1'b0, ch_r} + 4'd1 == n_r);
          obuf_r   <= {samples_r, rep_r.mx, rep_r.mn, msq_r - msq_mean_r, mean_r, ch_r};
          ch_r     <= ch_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obuf_r;
  assign out_tlast  = olast_r;
endmodule
`default_nettype wire

// ===== hdl/its_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module its_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic out_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out word dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready) else $error("input taken mid report");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |=> !in_tready || !out_tvalid) else $error("bad ready");
endmodule
bind interval_timing_statistics_top its_checker u_chk (.*);
`default_nettype wire
